/* rtl/core/ttcc_pkg.sv */
package ttcc_pkg;

   localparam int SCREEN_WIDTH_PIXELS_DEF = 768;
   localparam int SCREEN_HEIGHT_LINES_DEF = 896;
   localparam int CELL_SIZE               = 8;
   localparam int CELL_LOG                = 3;
   localparam int WORD_BITS               = 32;
   localparam int WORD_LOG                = 5;
   localparam int TAB_LOG                 = 3;
   localparam int QUEUE_DEPTH_DEF         = 2;

   localparam int CHAR_W   = 8;
   localparam int GLYPH_W  = 7;
   localparam int OFFSET_W = 15;
   localparam int SHIFT_W  = 5;
   localparam int OP_W     = 3;

   localparam logic [OP_W-1:0] OP_PRINT = 3'd0;
   localparam logic [OP_W-1:0] OP_TAB   = 3'd1;
   localparam logic [OP_W-1:0] OP_CR    = 3'd2;
   localparam logic [OP_W-1:0] OP_BS    = 3'd3;
   localparam logic [OP_W-1:0] OP_LF    = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7e;

   localparam logic CMD_RENDER = 1'b0;
   localparam logic CMD_SCROLL = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [GLYPH_W-1:0] glyph;
   } ttcc_cmd_type;

   typedef struct packed {
      logic                command;
      logic [OFFSET_W-1:0] word_offset;
      logic [SHIFT_W-1:0]  bit_shift;
      logic [GLYPH_W-1:0]  glyph_code;
   } ttcc_rsp_type;

endpackage

/* rtl/core/ttcc_queue.sv */
module ttcc_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = ttcc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output item_type rd_data,
   output logic     empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* rtl/core/ttcc_front.sv */
module ttcc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [7:0]                 char_code,
   output logic                       full,
   output logic                       q_wr_en,
   output ttcc_pkg::ttcc_cmd_type     q_wr_data,
   input  logic                       q_full
);
   import ttcc_pkg::*;

   logic         vld_ff, vld_in;
   ttcc_cmd_type cmd_ff, cmd_in;
   logic         keep;
   logic         accept;

   // classify
   always_comb begin
      keep      = 1'b1;
      cmd_in.op = OP_PRINT;
      cmd_in.glyph = char_code[GLYPH_W-1:0];
      case (char_code) inside
         [CHAR_FIRST:CHAR_LAST]: cmd_in.op = OP_PRINT;
         CHAR_TAB:               cmd_in.op = OP_TAB;
         CHAR_CR:                cmd_in.op = OP_CR;
         CHAR_BS:                cmd_in.op = OP_BS;
         CHAR_LF:                cmd_in.op = OP_LF;
         default:                keep = 1'b0;
      endcase
   end

   assign full      = vld_ff && q_full;
   assign accept    = push && !full;
   assign q_wr_en   = vld_ff && !q_full;
   assign q_wr_data = cmd_ff;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = keep;
      end else if (q_wr_en) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

/* rtl/core/ttcc_back.sv */
module ttcc_back #(
   parameter int SCREEN_WIDTH_PIXELS = ttcc_pkg::SCREEN_WIDTH_PIXELS_DEF,
   parameter int SCREEN_HEIGHT_LINES = ttcc_pkg::SCREEN_HEIGHT_LINES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   input  ttcc_pkg::ttcc_cmd_type cmd_data,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output ttcc_pkg::ttcc_rsp_type rsp_data
);
   import ttcc_pkg::*;

   localparam int TEXT_COLS   = SCREEN_WIDTH_PIXELS / CELL_SIZE;
   localparam int TEXT_ROWS   = SCREEN_HEIGHT_LINES / CELL_SIZE;
   localparam int WPL         = SCREEN_WIDTH_PIXELS / WORD_BITS;
   localparam int LINE_STRIDE = CELL_SIZE * WPL;
   localparam int COL_W       = $clog2(TEXT_COLS + 1);
   localparam int ROW_W       = $clog2(TEXT_ROWS);
   localparam int PX_W        = COL_W + CELL_LOG;
   localparam int OFF_W       =
      $clog2((TEXT_ROWS - 1) * LINE_STRIDE + (TEXT_COLS * CELL_SIZE) / WORD_BITS + 1);
   localparam logic [COL_W-1:0] COL_EDGE = COL_W'(TEXT_COLS);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TEXT_ROWS - 1);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PX_W-1:0]  px;
   logic [OFF_W-1:0] line_base;
   logic [OFF_W-1:0] word_off;
   logic [COL_W:0]   tab_stop;

   assign px        = {col_ff, {CELL_LOG{1'b0}}};
   assign line_base = OFF_W'(row_ff) * OFF_W'(LINE_STRIDE);
   assign word_off  = line_base + OFF_W'(px >> WORD_LOG);
   assign tab_stop  = {(COL_W + 1 - TAB_LOG)'(col_ff[COL_W-1:TAB_LOG])
                       + (COL_W + 1 - TAB_LOG)'(1), {(TAB_LOG - 1){1'b0}}, 1'b1};
   assign cmd_pop   = !cmd_empty && !rsp_full;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      rsp_push = 1'b0;
      rsp_data = '0;
      if (cmd_pop) begin
         case (cmd_data.op)
            OP_PRINT: begin
               if (col_ff < COL_EDGE) begin
                  rsp_push             = 1'b1;
                  rsp_data.command     = CMD_RENDER;
                  rsp_data.word_offset = OFFSET_W'(word_off);
                  rsp_data.bit_shift   = SHIFT_W'(px[WORD_LOG-1:0]);
                  rsp_data.glyph_code  = cmd_data.glyph;
                  col_in               = col_ff + COL_W'(1);
               end
            end
            OP_TAB: begin
               col_in = (tab_stop > (COL_W + 1)'(TEXT_COLS)) ? COL_EDGE
                                                             : tab_stop[COL_W-1:0];
            end
            OP_CR: begin
               col_in = '0;
            end
            OP_BS: begin
               if (col_ff != '0) begin
                  col_in = col_ff - COL_W'(1);
               end
            end
            OP_LF: begin
               if (row_ff >= ROW_LAST) begin
                  row_in           = ROW_LAST;
                  rsp_push         = 1'b1;
                  rsp_data.command = CMD_SCROLL;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
            default: begin
               col_in = col_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

/* rtl/core/text_terminal_cursor_controller.sv */
// Channel   Ports                                         Handshake
// input     req_char_code                                 push / full
// result    rsp_command rsp_word_offset rsp_bit_shift     empty / pop
//           rsp_glyph_code
//
// One character per cycle while full is low; the back end updates the cursor per pop.
// Results reach the rsp_ ports via the front register, command queue and result queue.
// Reset clears the cursor to column 0, row 0 and empties both queues.
// A stalled result side fills the result queue, then the command queue, then raises full.
// Characters other than printables, TAB, CR, BS and LF are dropped and take no slot.
module text_terminal_cursor_controller #(
   parameter int SCREEN_WIDTH_PIXELS = ttcc_pkg::SCREEN_WIDTH_PIXELS_DEF,
   parameter int SCREEN_HEIGHT_LINES = ttcc_pkg::SCREEN_HEIGHT_LINES_DEF,
   parameter int QUEUE_DEPTH         = ttcc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [7:0]  req_char_code,
   output logic        full,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_command,
   output logic [14:0] rsp_word_offset,
   output logic [4:0]  rsp_bit_shift,
   output logic [6:0]  rsp_glyph_code
);
   import ttcc_pkg::*;

   logic         cmd_wr_en, cmd_full, cmd_empty, cmd_pop;
   ttcc_cmd_type cmd_wr_data, cmd_rd_data;
   logic         out_wr_en, out_full;
   ttcc_rsp_type out_wr_data, out_rd_data;

   ttcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .char_code (req_char_code),
      .full      (full),
      .q_wr_en   (cmd_wr_en),
      .q_wr_data (cmd_wr_data),
      .q_full    (cmd_full)
   );

   ttcc_queue #(
      .item_type (ttcc_cmd_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_wr_en),
      .wr_data (cmd_wr_data),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   ttcc_back #(
      .SCREEN_WIDTH_PIXELS (SCREEN_WIDTH_PIXELS),
      .SCREEN_HEIGHT_LINES (SCREEN_HEIGHT_LINES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_rd_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (out_full),
      .rsp_push  (out_wr_en),
      .rsp_data  (out_wr_data)
   );

   ttcc_queue #(
      .item_type (ttcc_rsp_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_wr_en),
      .wr_data (out_wr_data),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (out_rd_data),
      .empty   (empty)
   );

   assign rsp_command     = out_rd_data.command;
   assign rsp_word_offset = out_rd_data.word_offset;
   assign rsp_bit_shift   = out_rd_data.bit_shift;
   assign rsp_glyph_code  = out_rd_data.glyph_code;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(out_wr_en && out_full))
      else $error("result pushed into a full queue");

   a_full_from_backlog: assert property (@(posedge clock) disable iff (reset)
      full |-> cmd_full)
      else $error("full raised with room in the command queue");

   a_scroll_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_command == CMD_SCROLL) |->
         (rsp_word_offset == '0 && rsp_bit_shift == '0 && rsp_glyph_code == '0))
      else $error("scroll item carries render fields");

   a_render_printable: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_command == CMD_RENDER) |->
         (rsp_glyph_code >= 7'h20 && rsp_glyph_code <= 7'h7e))
      else $error("render item with a control glyph");

endmodule
